@@ sv/c16mef_pkg.sv @@
// Package with the request and response types and the CRC-16/ARC helpers of the framer.
`timescale 1ns / 1ps

package c16mef_pkg;

   typedef enum logic [0:0] {
      KIND_START   = 1'b0,
      KIND_PAYLOAD = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] message_id;
      logic [15:0] payload_length;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
      logic       last_in_run;
   } rsp_type;

   localparam logic [15:0] MAX_PAYLOAD  = 16'd65529;
   localparam logic [15:0] HEADER_BYTES = 16'd6;
   localparam int          RESULT_MAX   = 6;
   localparam int          CNT_W        = $clog2(RESULT_MAX + 1);

   function automatic logic [15:0] nib_tab(input logic [3:0] idx);
      logic [15:0] val;
      case (idx)
         4'h0: val = 16'h0000;
         4'h1: val = 16'hCC01;
         4'h2: val = 16'hD801;
         4'h3: val = 16'h1400;
         4'h4: val = 16'hF001;
         4'h5: val = 16'h3C00;
         4'h6: val = 16'h2800;
         4'h7: val = 16'hE401;
         4'h8: val = 16'hA001;
         4'h9: val = 16'h6C00;
         4'hA: val = 16'h7800;
         4'hB: val = 16'hB401;
         4'hC: val = 16'h5000;
         4'hD: val = 16'h9C01;
         4'hE: val = 16'h8801;
         4'hF: val = 16'h4400;
         default: val = 16'h0000;
      endcase
      return val;
   endfunction

   function automatic logic [15:0] crc_nibble(input logic [15:0] crc, input logic [3:0] nib);
      return {4'h0, crc[15:4]} ^ nib_tab(crc[3:0]) ^ nib_tab(nib);
   endfunction

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] tmp;
      tmp = crc_nibble(crc, b[3:0]);
      return crc_nibble(tmp, b[7:4]);
   endfunction

endpackage

@@ sv/crc16_message_envelope_framer.sv @@
// Top level of the length-prefixed message framer with a CRC-16/ARC trailer.
//
// The request channel carries start and payload requests. A start request
// produces the total size and the message id, both low byte first, and for an
// empty payload also the two CRC bytes. Each payload request within a frame
// produces its byte, and the last one is followed by the CRC bytes. Payload
// requests outside a frame produce nothing; a start inside a frame abandons it.
// The response channel carries one byte per transfer, with frame_end on the
// high CRC byte and last_in_run on the final byte caused by a request.
// A request is held in an input register and turned into its response bytes
// combinationally as it moves into the output buffer, which offers the first
// byte. The output buffer sends one byte per cycle while the receiver takes them:
// a payload request yields one byte (three when it closes the frame), a start
// request four or six bytes. A new request is accepted while the input register
// is empty or its request moves into a buffer that is empty or has its last byte taken.
// When the receiver stalls, the buffer and then the input register fill and
// req_ready falls. Reset empties both and closes any open frame.
`timescale 1ns / 1ps

module crc16_message_envelope_framer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  c16mef_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output c16mef_pkg::rsp_type rsp_data
);

   logic                         in_valid_ff, in_valid_in;
   c16mef_pkg::req_type          in_data_ff;
   logic [7:0]                   buf_ff [c16mef_pkg::RESULT_MAX];
   logic [7:0]                   buf_in [c16mef_pkg::RESULT_MAX];
   logic [c16mef_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic                         end_ff, end_in;
   logic [15:0]                  crc_ff, crc_in;
   logic [15:0]                  rem_ff, rem_in;
   logic                         open_ff, open_in;

   logic [7:0]                   new_buf [c16mef_pkg::RESULT_MAX];
   logic [c16mef_pkg::CNT_W-1:0] new_cnt;
   logic                         new_end;
   logic [15:0]                  new_crc, new_rem;
   logic                         new_open;

   logic take, buf_free, advance, req_take;

   assign take      = rsp_valid && rsp_ready;
   assign buf_free  = (cnt_ff == '0) || (take && (cnt_ff == c16mef_pkg::CNT_W'(1)));
   assign advance   = in_valid_ff && buf_free;
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign rsp_valid             = (cnt_ff != '0);
   assign rsp_data.out_byte     = buf_ff[0];
   assign rsp_data.last_in_run  = (cnt_ff == c16mef_pkg::CNT_W'(1));
   assign rsp_data.frame_end    = end_ff && (cnt_ff == c16mef_pkg::CNT_W'(1));

   always_comb begin : compute
      logic [15:0] len_sat;
      logic [15:0] size;
      logic [15:0] crc_hdr;
      logic [15:0] crc_pay;
      logic [15:0] rem_dec;
      len_sat = (in_data_ff.payload_length > c16mef_pkg::MAX_PAYLOAD) ?
                c16mef_pkg::MAX_PAYLOAD : in_data_ff.payload_length;
      size    = len_sat + c16mef_pkg::HEADER_BYTES;
      crc_hdr = c16mef_pkg::crc_byte(16'h0000, size[7:0]);
      crc_hdr = c16mef_pkg::crc_byte(crc_hdr, size[15:8]);
      crc_hdr = c16mef_pkg::crc_byte(crc_hdr, in_data_ff.message_id[7:0]);
      crc_hdr = c16mef_pkg::crc_byte(crc_hdr, in_data_ff.message_id[15:8]);
      crc_pay = c16mef_pkg::crc_byte(crc_ff, in_data_ff.data_byte);
      rem_dec = rem_ff - 16'd1;
      for (int i = 0; i < c16mef_pkg::RESULT_MAX; i++) begin
         new_buf[i] = 8'h00;
      end
      new_cnt  = '0;
      new_end  = 1'b0;
      new_crc  = crc_ff;
      new_rem  = rem_ff;
      new_open = open_ff;
      case (in_data_ff.kind)
         c16mef_pkg::KIND_START: begin
            new_buf[0] = size[7:0];
            new_buf[1] = size[15:8];
            new_buf[2] = in_data_ff.message_id[7:0];
            new_buf[3] = in_data_ff.message_id[15:8];
            new_buf[4] = crc_hdr[7:0];
            new_buf[5] = crc_hdr[15:8];
            new_crc    = crc_hdr;
            new_rem    = len_sat;
            new_open   = (len_sat != 16'd0);
            new_end    = (len_sat == 16'd0);
            new_cnt    = (len_sat == 16'd0) ? c16mef_pkg::CNT_W'(6) : c16mef_pkg::CNT_W'(4);
         end
         c16mef_pkg::KIND_PAYLOAD: begin
            if (open_ff) begin
               new_buf[0] = in_data_ff.data_byte;
               new_buf[1] = crc_pay[7:0];
               new_buf[2] = crc_pay[15:8];
               new_crc    = crc_pay;
               new_rem    = rem_dec;
               new_open   = (rem_dec != 16'd0);
               new_end    = (rem_dec == 16'd0);
               new_cnt    = (rem_dec == 16'd0) ? c16mef_pkg::CNT_W'(3) : c16mef_pkg::CNT_W'(1);
            end
         end
         default: begin
            new_cnt = '0;
         end
      endcase
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      buf_in  = buf_ff;
      cnt_in  = cnt_ff;
      end_in  = end_ff;
      crc_in  = crc_ff;
      rem_in  = rem_ff;
      open_in = open_ff;
      if (advance) begin
         buf_in  = new_buf;
         cnt_in  = new_cnt;
         end_in  = new_end;
         crc_in  = new_crc;
         rem_in  = new_rem;
         open_in = new_open;
      end else if (take) begin
         for (int i = 0; i < c16mef_pkg::RESULT_MAX - 1; i++) begin
            buf_in[i] = buf_ff[i+1];
         end
         cnt_in = cnt_ff - c16mef_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      buf_ff <= buf_in;
      end_ff <= end_in;
      if (reset) begin
         in_valid_ff <= 1'b0;
         cnt_ff      <= '0;
         crc_ff      <= 16'h0000;
         rem_ff      <= 16'h0000;
         open_ff     <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         cnt_ff      <= cnt_in;
         crc_ff      <= crc_in;
         rem_ff      <= rem_in;
         open_ff     <= open_in;
      end
   end

   a_cnt_bound : assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= c16mef_pkg::CNT_W'(c16mef_pkg::RESULT_MAX))
      else $error("response count exceeds the buffer depth");

   a_open_rem : assert property (@(posedge clock) disable iff (reset)
      open_ff == (rem_ff != 16'd0))
      else $error("open frame and remaining byte count disagree");

   a_end_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.frame_end) |-> (rsp_data.last_in_run && !open_ff))
      else $error("frame end shown while the frame is still open");

   a_load_free : assert property (@(posedge clock) disable iff (reset)
      (take && !rsp_data.last_in_run) |=> (cnt_ff == $past(cnt_ff) - c16mef_pkg::CNT_W'(1)))
      else $error("buffer reloaded before its last byte was taken");

endmodule
